/* rtl/pcg32_random_generator_top_defines.svh */
// Assertion macros for the PCG32 generator.
// Taken in by the top level with an include; no other dependencies.
`ifndef PCG32_RANDOM_GENERATOR_TOP_DEFINES_SVH
`define PCG32_RANDOM_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pcg32_pkg.sv */
// Shared constants and controller/datapath command types for the PCG32 generator.
// No dependencies.
package pcg32_pkg;

  localparam logic [63:0] RESET_STATE      = 64'd12345;
  localparam logic [63:0] RESET_INCREMENT  = 64'h14057B7EF767814F;
  localparam logic [63:0] RESET_MULTIPLIER = 64'h5851F42D4C957F2D;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
  // SplitMix64 output for an input of zero, used when the mix of the seed is zero
  localparam logic [63:0] MIX_OF_ZERO  = 64'hE220A8397B1DCDAF;

  // Step of the 64x64 low-half multiply on the shared 32x32 multiplier
  typedef enum logic [1:0] {
    MS_LL,    // product of low halves
    MS_LH,    // add low product, multiply a low by b high
    MS_HL,    // add cross term, multiply a high by b low
    MS_LAST   // add last cross term
  } mstep_t;

  typedef struct packed {
    logic   cfg_write;
    logic   load_draw;
    logic   load_reseed;
    logic   mul_en;
    mstep_t mstep;
    logic   load_mix2;
    logic   commit_draw;
    logic   commit_reseed;
    logic   push_out;
  } pcg_cmd_t;

endpackage

/* rtl/pcg32_datapath.sv */
// PCG32 datapath: generator state, multiplier register, shared 32x32 multiplier,
// accumulator and result word. Uses pcg32_pkg; driven by pcg32_ctrl commands.
module pcg32_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pcg32_pkg::pcg_cmd_t cmd,
  input  logic [63:0]         cfg_data,
  input  logic [63:0]         seed,
  input  logic [63:0]         stream,
  output logic [31:0]         random_word
);

  logic [63:0] lcg_state;
  logic [63:0] lcg_increment;
  logic [63:0] lcg_multiplier;

  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [63:0] stream_q;
  logic [31:0] word;

  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_p;
  logic [63:0] seed_t;
  logic [63:0] mix1;
  logic [63:0] mix2_in;
  logic [63:0] mix_out;
  logic [63:0] xsh;
  logic [31:0] xsh_word;
  logic [63:0] rot_dbl;

  // XSH-RR output of the current state
  assign xsh      = lcg_state ^ (lcg_state >> 18);
  assign xsh_word = xsh[58:27];
  assign rot_dbl  = {xsh_word, xsh_word} >> lcg_state[63:59];

  assign seed_t  = seed + pcg32_pkg::GOLDEN_GAMMA;
  assign mix1    = seed_t ^ (seed_t >> 30);
  assign mix2_in = acc ^ (acc >> 27);
  assign mix_out = acc ^ (acc >> 31);

  always_comb begin
    unique case (cmd.mstep)
      pcg32_pkg::MS_LL: begin
        mul_x = op_a[31:0];
        mul_y = op_b[31:0];
      end
      pcg32_pkg::MS_LH: begin
        mul_x = op_a[31:0];
        mul_y = op_b[63:32];
      end
      pcg32_pkg::MS_HL: begin
        mul_x = op_a[63:32];
        mul_y = op_b[31:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state      <= pcg32_pkg::RESET_STATE;
      lcg_increment  <= pcg32_pkg::RESET_INCREMENT;
      lcg_multiplier <= pcg32_pkg::RESET_MULTIPLIER;
    end else begin
      if (cmd.cfg_write) begin
        lcg_multiplier <= cfg_data;
      end
      if (cmd.commit_draw) begin
        lcg_state <= acc;
      end
      if (cmd.commit_reseed) begin
        lcg_state     <= (mix_out == 64'd0) ? pcg32_pkg::MIX_OF_ZERO : mix_out;
        lcg_increment <= stream_q | 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_draw) begin
      op_a <= lcg_state;
      op_b <= lcg_multiplier;
      acc  <= lcg_increment;
      word <= rot_dbl[31:0];
    end else if (cmd.load_reseed) begin
      op_a     <= mix1;
      op_b     <= pcg32_pkg::MIX_MUL_A;
      acc      <= '0;
      stream_q <= stream;
    end else if (cmd.load_mix2) begin
      op_a <= mix2_in;
      op_b <= pcg32_pkg::MIX_MUL_B;
      acc  <= '0;
    end else if (cmd.mul_en) begin
      prod <= mul_p;
      unique case (cmd.mstep)
        pcg32_pkg::MS_LL:   acc <= acc;
        pcg32_pkg::MS_LH:   acc <= acc + prod;
        pcg32_pkg::MS_HL:   acc <= acc + {prod[31:0], 32'd0};
        pcg32_pkg::MS_LAST: acc <= acc + {prod[31:0], 32'd0};
      endcase
    end
    if (cmd.push_out) begin
      random_word <= word;
    end
  end

endmodule

/* rtl/pcg32_ctrl.sv */
// PCG32 controller: sequences draws and reseeds, owns the handshakes.
// Uses pcg32_pkg; issues commands to pcg32_datapath.
module pcg32_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                mode,
  input  logic                rsp_stall,
  input  logic                cfg_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  output logic                cfg_ready,
  output pcg32_pkg::pcg_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LL,
    ST_LH,
    ST_HL,
    ST_LAST,
    ST_MIX2,
    ST_DONE
  } state_t;

  state_t state;
  logic   is_reseed;
  logic   phase2;
  logic   out_free;
  logic   req_take;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign req_take  = req_valid && (state == ST_IDLE);

  always_comb begin
    cmd               = '0;
    cmd.mstep         = pcg32_pkg::MS_LL;
    cmd.cfg_write     = cfg_valid && (state == ST_IDLE);
    cmd.load_draw     = req_take && !mode;
    cmd.load_reseed   = req_take && mode;
    unique case (state)
      ST_LL: begin
        cmd.mul_en = 1'b1;
        cmd.mstep  = pcg32_pkg::MS_LL;
      end
      ST_LH: begin
        cmd.mul_en = 1'b1;
        cmd.mstep  = pcg32_pkg::MS_LH;
      end
      ST_HL: begin
        cmd.mul_en = 1'b1;
        cmd.mstep  = pcg32_pkg::MS_HL;
      end
      ST_LAST: begin
        cmd.mul_en = 1'b1;
        cmd.mstep  = pcg32_pkg::MS_LAST;
      end
      ST_MIX2: cmd.load_mix2 = 1'b1;
      ST_DONE: begin
        cmd.commit_reseed = is_reseed;
        cmd.commit_draw   = !is_reseed && out_free;
        cmd.push_out      = !is_reseed && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      is_reseed <= 1'b0;
      phase2    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // a new word may replace one leaving in the same cycle
      if (state == ST_DONE && !is_reseed && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            is_reseed <= mode;
            phase2    <= 1'b0;
            state     <= ST_LL;
          end
        end
        ST_LL:   state <= ST_LH;
        ST_LH:   state <= ST_HL;
        ST_HL:   state <= ST_LAST;
        ST_LAST: begin
          if (is_reseed && !phase2) begin
            state <= ST_MIX2;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_MIX2: begin
          phase2 <= 1'b1;
          state  <= ST_LL;
        end
        ST_DONE: begin
          if (is_reseed) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/pcg32_random_generator_top.sv */
// Channel | signals                       | payload
// req     | req_valid, req_stall          | mode, seed, stream
// rsp     | rsp_valid, rsp_stall          | random_word
// cfg     | cfg_valid, cfg_ready          | cfg_data (lcg_multiplier)
//
// From a draw's transfer to the next free slot, four steps of the
// shared 32x32 multiplier build the 64-bit state update, plus finish and accept.
// A reseed runs two SplitMix64 multiplies on the same multiplier.
// rst is synchronous, active high; it restores state, increment and multiplier.
// A finished draw waits in the done step while rsp is stalled with a result held.
//
// Top level of the PCG32 XSH-RR generator; uses pcg32_pkg, pcg32_ctrl,
// pcg32_datapath and the assertion macros in pcg32_random_generator_top_defines.svh.
`include "pcg32_random_generator_top_defines.svh"

module pcg32_random_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        mode,
  input  logic [63:0] seed,
  input  logic [63:0] stream,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] random_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  pcg32_pkg::pcg_cmd_t cmd;

  pcg32_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .mode      (mode),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  pcg32_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_data    (cfg_data),
    .seed        (seed),
    .stream      (stream),
    .random_word (random_word)
  );

  `PCG_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall, "not busy after request transfer")
  `PCG_ASSERT_NEXT(a_no_cfg_in_work, req_valid && !req_stall, !cfg_ready, "config open while item in work")
  `PCG_ASSERT_NOW(a_rsp_after_work, $rose(rsp_valid), $past(req_stall), "result without work")

endmodule

/* test/tb_pcg32_random_generator_top.sv */
// Self-checking testbench for pcg32_random_generator_top: draws and reseeds
// against an in-bench XSH-RR predictor, under random stalls and gaps.
// Depends on pcg32_pkg and the RTL of pcg32_random_generator_top.
module tb_pcg32_random_generator_top;

  localparam int unsigned RUN_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned PHASE_ITEMS = 85;
  // SplitMix64 of this seed is zero: seed + golden gamma wraps to zero
  localparam logic [63:0] ZERO_MIX_SEED = 64'h61C8864680B583EB;

  typedef struct packed {
    logic        mode;
    logic [63:0] seed;
    logic [63:0] stream;
  } gen_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        mode = 1'b0;
  logic [63:0] seed = '0;
  logic [63:0] stream = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [31:0] random_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;

  // predictor copy of the generator
  logic [63:0] gen_state;
  logic [63:0] gen_inc;
  logic [63:0] gen_mult;

  gen_req_t    pending_reqs[$];
  logic [31:0] expected_words[$];
  int unsigned queued_count = 0;
  int unsigned taken_count = 0;
  int unsigned fail_count = 0;
  bit          req_taken = 1'b0;
  bit          calm = 1'b0;
  int unsigned req_gap = 0;
  int unsigned stall_left = 0;

  pcg32_random_generator_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .mode        (mode),
    .seed        (seed),
    .stream      (stream),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .random_word (random_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] splitmix(input logic [63:0] v);
    logic [63:0] t;
    t = v + pcg32_pkg::GOLDEN_GAMMA;
    t = (t ^ (t >> 30)) * pcg32_pkg::MIX_MUL_A;
    t = (t ^ (t >> 27)) * pcg32_pkg::MIX_MUL_B;
    return t ^ (t >> 31);
  endfunction

  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] x;
    logic [31:0] w;
    logic [63:0] both;
    x = s ^ (s >> 18);
    w = x[58:27];
    both = {w, w} >> s[63:59];
    return both[31:0];
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic apply_request(input logic m, input logic [63:0] sd, input logic [63:0] st);
    logic [63:0] mixed;
    if (m) begin
      mixed = splitmix(sd);
      if (mixed == 64'd0) mixed = splitmix(64'd0);
      gen_state = mixed;
      gen_inc = st | 64'd1;
    end else begin
      expected_words.push_back(xsh_rr(gen_state));
      gen_state = gen_state * gen_mult + gen_inc;
    end
  endtask

  task automatic queue_req(input logic m, input logic [63:0] sd, input logic [63:0] st);
    gen_req_t r;
    r.mode = m;
    r.seed = sd;
    r.stream = st;
    pending_reqs.push_back(r);
    queued_count++;
  endtask

  // all transfers taken, all words back, then time for a trailing reseed
  task automatic wait_idle();
    while (taken_count != queued_count || expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_multiplier(input logic [63:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    gen_mult = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin
    gen_req_t r;
    logic     nv;
    if (!rst && !(req_valid && !req_taken)) begin
      nv = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        nv = 1'b1;
        mode <= r.mode;
        seed <= r.seed;
        stream <= r.stream;
        if (!calm && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 10);
      end
      req_valid <= nv;
    end
    req_taken = 1'b0;
  end

  // response stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // monitor: predict on request transfer, check on response transfer
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst) begin
      if (req_valid && req_stall === 1'b0) begin
        req_taken = 1'b1;
        taken_count++;
        apply_request(mode, seed, stream);
      end
      if (rsp_valid === 1'b1 && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          $error("random_word: expected none, actual %h", random_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (random_word !== want) begin
            $error("random_word: expected %h, actual %h", want, random_word);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("pcg32_random_generator_top test failed");
    $finish;
  end

  initial begin
    logic [63:0] mults[$];
    int unsigned p;
    int unsigned k;
    int unsigned pick;
    gen_state = pcg32_pkg::RESET_STATE;
    gen_inc = pcg32_pkg::RESET_INCREMENT;
    gen_mult = pcg32_pkg::RESET_MULTIPLIER;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset state, ignored fields, seed and stream extremes, zero mix
    queue_req(1'b0, '0, '0);
    queue_req(1'b0, '0, '0);
    queue_req(1'b0, '1, '1);
    queue_req(1'b1, '0, '0);
    queue_req(1'b0, '0, '0);
    queue_req(1'b0, rand64(), rand64());
    queue_req(1'b1, '1, '1);
    queue_req(1'b0, '0, '0);
    queue_req(1'b0, '0, '0);
    queue_req(1'b1, ZERO_MIX_SEED, rand64());
    queue_req(1'b0, '0, '0);
    queue_req(1'b0, '0, '0);
    queue_req(1'b1, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
    queue_req(1'b0, '0, '0);
    queue_req(1'b1, rand64(), 64'hAAAA_AAAA_AAAA_AAAA);
    queue_req(1'b0, '0, '0);
    queue_req(1'b0, '1, '1);
    queue_req(1'b0, '0, '0);

    mults.push_back(64'd0);
    mults.push_back('1);
    mults.push_back(64'd1);
    mults.push_back(64'h8000_0000_0000_0000);
    mults.push_back(rand64() | 64'd1);
    mults.push_back(rand64() & ~64'd1);
    mults.push_back(pcg32_pkg::RESET_MULTIPLIER);

    for (p = 0; p < mults.size(); p++) begin
      wait_idle();
      if (p == mults.size() - 1) calm = 1'b1;
      write_multiplier(mults[p]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) queue_req(1'b0, rand64(), rand64());
        else if (pick < 19) queue_req(1'b1, rand64(), rand64());
        else queue_req(1'b1, ZERO_MIX_SEED, rand64());
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("pcg32_random_generator_top test passed");
    end else begin
      $display("pcg32_random_generator_top test failed");
    end
    $finish;
  end

endmodule
